// File: rtl/kmc_pkg.sv
`default_nettype none
package kmc_pkg;

  localparam int MAX_CLUSTERS_DEF = 8;
  localparam int MAX_DIMS_DEF = 8;
  localparam int MAX_POINTS_DEF = 1024;

  // Depth of the command queue between the front and back parts.
  localparam int CMD_QUEUE_DEPTH = 4;

  localparam logic [1:0] OP_LOAD_MEAN = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_END_PASS = 2'd2;

  localparam logic [1:0] REG_DIMS = 2'd0;
  localparam logic [1:0] REG_CLUSTERS = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;
  localparam logic [1:0] REG_MAXPASS = 2'd3;

  localparam logic [3:0] NO_CLUSTER = 4'd15;
  localparam logic [8:0] PASS_SAT = 9'd511;
  localparam logic [10:0] CHANGE_SAT = 11'd2047;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [9:0]         item_index;
    logic [2:0]         coord_index;
    logic signed [15:0] coord_value;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [9:0]  point_number;
    logic [2:0]  nearest_cluster;
    logic        membership_changed;
    logic [10:0] change_count;
    logic        converged;
    logic        pass_limit_hit;
    logic [8:0]  passes_done;
  } out_item_t;

  // Command word handed from the front part to the back part.
  typedef struct packed {
    logic [1:0]         opcode;
    logic [9:0]         item_index;
    logic [2:0]         coord_index;
    logic signed [15:0] coord_value;
    logic               last_coord;
  } cmd_t;

  // Clamped configuration seen by the back part.
  typedef struct packed {
    logic [4:0]  dims;
    logic [4:0]  clusters;
    logic [10:0] threshold;
    logic [8:0]  max_passes;
  } cfg_t;

endpackage
`default_nettype wire

// File: rtl/kmeans_cluster_pass.sv
`default_nettype none
// Lloyd k-means pass engine. Words are accepted when start is high and busy is low;
// a front queue of four words takes them while the back sequencer works. After reset
// the back part marks every point as unassigned, so busy rises once four words wait.
// Mean loads and non-final point coordinates are stored straight from the idle state.
// A point's last coordinate starts a search with one mean-store read and one multiply
// per dimension of each cluster, then a read-modify-write of each sum; an end-of-pass
// word takes one sum read, a serial divide and one mean write per dimension of each
// non-empty cluster, unless the pass converged. Results appear for one cycle on
// out_valid and the receiver cannot stall them.
module kmeans_cluster_pass
  import kmc_pkg::*;
#(
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
  parameter int MAX_DIMS = MAX_DIMS_DEF,
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_item,
  output logic          out_valid,
  output out_item_t     out_item,
  input  wire logic     psel,
  input  wire logic     penable,
  input  wire logic     pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [3:0]  dims_r, clus_r;
  logic [10:0] thr_r;
  logic [8:0]  maxp_r;
  cfg_t        cfg;
  logic        cmd_valid, cmd_pop;
  cmd_t        cmd;

  assign pready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= 4'd8;
      clus_r <= 4'd8;
      thr_r <= 11'd1;
      maxp_r <= 9'd300;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_DIMS:     dims_r <= pwdata[3:0];
        REG_CLUSTERS: clus_r <= pwdata[3:0];
        REG_THRESH:   thr_r <= pwdata[10:0];
        REG_MAXPASS:  maxp_r <= pwdata[8:0];
        default:      ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (paddr[3:2])
      REG_DIMS:     prdata = {28'd0, dims_r};
      REG_CLUSTERS: prdata = {28'd0, clus_r};
      REG_THRESH:   prdata = {21'd0, thr_r};
      REG_MAXPASS:  prdata = {23'd0, maxp_r};
      default:      prdata = '0;
    endcase
  end

  // Clamp the counts to what the stores hold.
  always_comb begin
    cfg.dims = (dims_r == 4'd0) ? 5'd1 :
               ({1'b0, dims_r} > 5'(MAX_DIMS)) ? 5'(MAX_DIMS) : {1'b0, dims_r};
    cfg.clusters = (clus_r == 4'd0) ? 5'd1 :
                   ({1'b0, clus_r} > 5'(MAX_CLUSTERS)) ? 5'(MAX_CLUSTERS) : {1'b0, clus_r};
    cfg.threshold = thr_r;
    cfg.max_passes = maxp_r;
  end

  kmc_front #(.MAX_CLUSTERS(MAX_CLUSTERS), .MAX_DIMS(MAX_DIMS), .MAX_POINTS(MAX_POINTS))
    u_front (.clk, .rst_n, .start, .busy, .in_item, .cfg, .cmd_valid, .cmd, .cmd_pop);

  kmc_back #(.MAX_CLUSTERS(MAX_CLUSTERS), .MAX_DIMS(MAX_DIMS), .MAX_POINTS(MAX_POINTS))
    u_back (.clk, .rst_n, .cmd_valid, .cmd, .cmd_pop, .cfg, .out_valid, .out_item);

endmodule
`default_nettype wire

// File: rtl/kmc_front.sv
`default_nettype none
module kmc_front
  import kmc_pkg::*;
#(
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
  parameter int MAX_DIMS = MAX_DIMS_DEF,
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_item,
  input  wire cfg_t     cfg,
  output logic          cmd_valid,
  output cmd_t          cmd,
  input  wire logic     cmd_pop
);

  localparam int QD = CMD_QUEUE_DEPTH;
  localparam int QW = $clog2(QD);

  cmd_t            q_r [QD];
  logic [QW-1:0]   wp_r, rp_r;
  logic [QW:0]     cnt_r;
  logic            push;
  cmd_t            c_in;
  logic            keep;
  logic [4:0]      dim_ext;
  logic [16:0]     item_ext;

  // Classify the word: drop anything that leaves no trace.
  always_comb begin
    dim_ext = {2'b00, in_item.coord_index};
    item_ext = {7'd0, in_item.item_index};
    c_in.opcode = in_item.opcode;
    c_in.item_index = in_item.item_index;
    c_in.coord_index = in_item.coord_index;
    c_in.coord_value = in_item.coord_value;
    c_in.last_coord = (dim_ext == cfg.dims - 5'd1) && (item_ext < 17'(MAX_POINTS));
    unique case (in_item.opcode)
      OP_LOAD_MEAN: keep = ({7'd0, in_item.item_index} < 17'(MAX_CLUSTERS)) &&
                           (dim_ext < 5'(MAX_DIMS));
      OP_POINT:     keep = dim_ext < 5'(MAX_DIMS);
      OP_END_PASS:  keep = 1'b1;
      default:      keep = 1'b0;
    endcase
  end

  assign busy = (cnt_r == (QW+1)'(QD));
  assign push = start && !busy && keep;
  assign cmd_valid = (cnt_r != '0);
  assign cmd = q_r[rp_r];

  // Command queue storage.
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= c_in;
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (cmd_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QW+1)'(push) - (QW+1)'(cmd_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid) else $error("pop from empty queue");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> cnt_r <= (QW+1)'(QD)) else $error("queue overflow");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !cmd_pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count slip");
`endif

endmodule
`default_nettype wire

// File: rtl/kmc_back.sv
`default_nettype none
module kmc_back
  import kmc_pkg::*;
#(
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
  parameter int MAX_DIMS = MAX_DIMS_DEF,
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  input  wire cfg_t cfg,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int CW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int PW = $clog2(MAX_POINTS);
  localparam int MD = MAX_CLUSTERS * MAX_DIMS;
  localparam int MW = CW + DW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIST = 4'd1;
  localparam logic [3:0] S_MEMB = 4'd2;
  localparam logic [3:0] S_ACC = 4'd3;
  localparam logic [3:0] S_ACCW = 4'd4;
  localparam logic [3:0] S_UPD = 4'd5;
  localparam logic [3:0] S_DIVS = 4'd6;
  localparam logic [3:0] S_DIVR = 4'd7;
  localparam logic [3:0] S_DIVW = 4'd8;
  localparam logic [3:0] S_CLRM = 4'd9;
  localparam logic [3:0] S_CLR = 4'd10;
  localparam logic [3:0] S_DIST2 = 4'd11;
  localparam logic [3:0] S_MINIT = 4'd12;

  logic [3:0] st_r;
  cmd_t       cm_r;

  // Memories: means, sums, membership.
  logic signed [15:0] mean_mem [MD];
  logic signed [26:0] sum_mem [MD];
  logic [3:0]         memb_mem [MAX_POINTS];
  logic [PW-1:0]      init_r;
  logic signed [15:0] mean_rd_r;
  logic signed [26:0] sum_rd_r;
  logic [3:0]         memb_rd_r;
  logic [MW-1:0]      m_ra, m_wa, s_ra, s_wa;
  logic               m_we, s_we;
  logic signed [15:0] m_wd;
  logic signed [26:0] s_wd;

  logic signed [15:0] pbuf_r [MAX_DIMS];
  logic [10:0]        ccnt_r [MAX_CLUSTERS];
  logic [MD-1:0]      sum_ok_r;
  logic [10:0]        chg_r;
  logic [8:0]         pass_r;

  logic [CW-1:0] c_r, best_c_r;
  logic [DW-1:0] d_r;
  logic [4:0]    c_ext, d_ext;
  logic [37:0]   dist_r, best_r;
  logic          first_r, pend_r;
  logic signed [16:0] diff_r;
  logic [33:0]   sq_r;
  logic          sq_v_r, sq_last_r;
  logic          conv_r, lim_r;
  out_item_t     pt_word, sum_word;

  // Restoring divider for sum / count.
  logic [26:0] dq_r, drem_r;
  logic        dneg_r;
  logic [4:0]  dstep_r;
  logic [27:0] dtrial;
  logic signed [27:0] qs;
  logic signed [15:0] qsat;
  logic [10:0] dcnt;

  assign c_ext = 5'(c_r);
  assign d_ext = 5'(d_r);
  assign dcnt = ccnt_r[c_r];

  // Memory ports.
  always_comb begin
    m_ra = {c_r, d_r};
    m_wa = {cm_r.item_index[CW-1:0], cm_r.coord_index[DW-1:0]};
    m_we = 1'b0;
    m_wd = cm_r.coord_value;
    s_ra = {best_c_r, d_r};
    s_wa = {best_c_r, d_r};
    s_we = 1'b0;
    s_wd = 27'(sum_ok_r[{best_c_r, d_r}] ? sum_rd_r : 27'sd0) + 27'(pbuf_r[d_r]);
    if (st_r == S_IDLE && cmd_valid && cmd.opcode == OP_LOAD_MEAN) begin
      m_wa = {cmd.item_index[CW-1:0], cmd.coord_index[DW-1:0]};
      m_wd = cmd.coord_value;
      m_we = 1'b1;
    end
    if (st_r == S_DIVW) begin
      m_wa = {c_r, d_r};
      m_wd = qsat;
      m_we = 1'b1;
    end
    if (st_r == S_DIVS || st_r == S_DIVR) s_ra = {c_r, d_r};
    if (st_r == S_ACCW) s_we = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (m_we) mean_mem[m_wa] <= m_wd;
    mean_rd_r <= mean_mem[m_ra];
  end

  always_ff @(posedge clk) begin
    if (s_we) sum_mem[s_wa] <= s_wd;
    sum_rd_r <= sum_mem[s_ra];
  end

  // Membership store: cleared to no cluster after reset, then updated per point.
  always_ff @(posedge clk) begin
    if (st_r == S_MINIT)
      memb_mem[init_r] <= NO_CLUSTER;
    else if (st_r == S_MEMB && memb_rd_r != 4'(best_c_r))
      memb_mem[cm_r.item_index[PW-1:0]] <= 4'(best_c_r);
    memb_rd_r <= memb_mem[cm_r.item_index[PW-1:0]];
  end

  // Result words for a point and for a pass summary.
  always_comb begin
    pt_word = '0;
    pt_word.point_number = cm_r.item_index;
    pt_word.nearest_cluster = 3'(best_c_r);
    pt_word.membership_changed = memb_rd_r != 4'(best_c_r);
    sum_word = '0;
    sum_word.result_kind = 1'b1;
    sum_word.change_count = chg_r;
    sum_word.converged = conv_r;
    sum_word.pass_limit_hit = lim_r;
    sum_word.passes_done = pass_r;
  end

  // Division arithmetic.
  always_comb begin
    dtrial = {drem_r, dq_r[26]} - {17'd0, dcnt};
    qs = dneg_r ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});
    if (qs > 28'sd32767) qsat = 16'sh7fff;
    else if (qs < -28'sd32768) qsat = -16'sh8000;
    else qsat = qs[15:0];
  end

  assign cmd_pop = (st_r == S_IDLE) && cmd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_MINIT;
      init_r <= '0;
      out_valid <= 1'b0;
      sum_ok_r <= '0;
      chg_r <= '0;
      pass_r <= '0;
      for (int i = 0; i < MAX_CLUSTERS; i++) ccnt_r[i] <= '0;
      sq_v_r <= 1'b0;
      sq_last_r <= 1'b0;
      dstep_r <= '0;
    end else begin
      out_valid <= 1'b0;
      sq_v_r <= 1'b0;
      unique case (st_r)
        // One membership entry per cycle after reset.
        S_MINIT: begin
          init_r <= init_r + 1'b1;
          if (init_r == PW'(MAX_POINTS - 1)) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cm_r <= cmd;
            if (cmd.opcode == OP_POINT) begin
              pbuf_r[cmd.coord_index[DW-1:0]] <= cmd.coord_value;
              if (cmd.last_coord) begin
                c_r <= '0;
                d_r <= '0;
                first_r <= 1'b1;
                dist_r <= '0;
                pend_r <= 1'b0;
                st_r <= S_DIST;
              end
            end else if (cmd.opcode == OP_END_PASS) begin
              conv_r <= chg_r < cfg.threshold;
              lim_r <= ((pass_r == PASS_SAT) ? pass_r : pass_r + 9'd1) >= cfg.max_passes;
              if (pass_r != PASS_SAT) pass_r <= pass_r + 9'd1;
              c_r <= '0;
              d_r <= '0;
              st_r <= S_UPD;
            end
          end
        end
        // Each dimension passes through S_DIST and S_DIST2: read, subtract, square, accumulate.
        S_DIST: begin
          if (sq_v_r) dist_r <= dist_r + 38'(sq_r);
          st_r <= S_DIST2;
        end
        S_DIST2: begin
          diff_r <= 17'(pbuf_r[d_r]) - 17'(mean_rd_r);
          pend_r <= 1'b1;
          if (pend_r) begin
            sq_r <= 34'($signed(diff_r) * $signed(diff_r));
            sq_v_r <= 1'b1;
            sq_last_r <= 1'b0;
          end
          if (sq_v_r) dist_r <= dist_r + 38'(sq_r);
          if (d_ext == cfg.dims - 5'd1) begin
            d_r <= '0;
            st_r <= S_ACC;
          end else begin
            d_r <= d_r + 1'b1;
            st_r <= S_DIST;
          end
        end
        // Drain the pipe and decide the current cluster.
        S_ACC: begin
          if (pend_r) begin
            sq_r <= 34'($signed(diff_r) * $signed(diff_r));
            sq_v_r <= 1'b1;
            pend_r <= 1'b0;
            if (sq_v_r) dist_r <= dist_r + 38'(sq_r);
          end else if (sq_v_r) begin
            dist_r <= dist_r + 38'(sq_r);
          end else begin
            if (first_r || dist_r < best_r) begin
              best_r <= dist_r;
              best_c_r <= c_r;
            end
            first_r <= 1'b0;
            dist_r <= '0;
            if (c_ext == cfg.clusters - 5'd1) begin
              st_r <= S_MEMB;
            end else begin
              c_r <= c_r + 1'b1;
              st_r <= S_DIST;
            end
          end
        end
        S_MEMB: begin
          out_valid <= 1'b1;
          out_item <= pt_word;
          if (memb_rd_r != 4'(best_c_r)) begin
            if (chg_r != CHANGE_SAT) chg_r <= chg_r + 11'd1;
          end
          ccnt_r[best_c_r] <= ccnt_r[best_c_r] + 11'd1;
          d_r <= '0;
          st_r <= S_CLRM;
        end
        S_CLRM: st_r <= S_ACCW;
        // Read-modify-write of one sum: read in S_CLRM, write in S_ACCW.
        S_ACCW: begin
          sum_ok_r[{best_c_r, d_r}] <= 1'b1;
          if (d_ext == cfg.dims - 5'd1) st_r <= S_IDLE;
          else begin
            d_r <= d_r + 1'b1;
            st_r <= S_CLRM;
          end
        end
        // Walk the clusters and dimensions for the new means, skipping empty clusters and converged passes.
        S_UPD: begin
          if (conv_r || c_ext >= cfg.clusters) st_r <= S_CLR;
          else if (dcnt == '0) begin
            if (c_ext == cfg.clusters - 5'd1) st_r <= S_CLR;
            else c_r <= c_r + 1'b1;
          end else st_r <= S_DIVS;
        end
        S_DIVS: st_r <= S_DIVR;
        S_DIVR: begin
          if (dstep_r == 5'd0 && !sq_last_r) begin
            dneg_r <= sum_ok_r[{c_r, d_r}] && sum_rd_r[26];
            dq_r <= (sum_ok_r[{c_r, d_r}] && sum_rd_r[26]) ? 27'(-sum_rd_r) :
                    (sum_ok_r[{c_r, d_r}] ? 27'(sum_rd_r) : 27'd0);
            drem_r <= '0;
            sq_last_r <= 1'b1;
          end else begin
            if (!dtrial[27]) begin
              drem_r <= dtrial[26:0];
              dq_r <= {dq_r[25:0], 1'b1};
            end else begin
              drem_r <= {drem_r[25:0], dq_r[26]};
              dq_r <= {dq_r[25:0], 1'b0};
            end
            if (dstep_r == 5'd26) begin
              dstep_r <= '0;
              st_r <= S_DIVW;
            end else dstep_r <= dstep_r + 5'd1;
          end
        end
        S_DIVW: begin
          sq_last_r <= 1'b0;
          if (d_ext == cfg.dims - 5'd1) begin
            d_r <= '0;
            if (c_ext == cfg.clusters - 5'd1) st_r <= S_CLR;
            else begin
              c_r <= c_r + 1'b1;
              st_r <= S_UPD;
            end
          end else begin
            d_r <= d_r + 1'b1;
            st_r <= S_DIVS;
          end
        end
        S_CLR: begin
          out_valid <= 1'b1;
          out_item <= sum_word;
          if (conv_r || lim_r) pass_r <= '0;
          chg_r <= '0;
          sum_ok_r <= '0;
          for (int i = 0; i < MAX_CLUSTERS; i++) ccnt_r[i] <= '0;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> st_r == S_IDLE) else $error("pop outside idle");
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(st_r) == S_MEMB || $past(st_r) == S_CLR)) else $error("stray result");
  a_chg_sat: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(chg_r) == CHANGE_SAT && st_r != S_IDLE) |-> chg_r == CHANGE_SAT || chg_r == '0)
    else $error("change counter wrapped");
`endif

endmodule
`default_nettype wire

// File: test/kmc_checker.sv
`timescale 1ns / 100ps
module kmc_checker
  import kmc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic      busy,
  input  wire in_item_t  in_item,
  input  wire logic      out_valid,
  input  wire out_item_t out_item,
  input  wire logic      psel,
  input  wire logic      penable,
  input  wire logic      pwrite,
  input  wire logic      pready,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output int             fail_count,
  output int             pending
);

  // Shadow copy of the block's registers and storage.
  logic [3:0]         dims_reg;
  logic [3:0]         clusters_reg;
  logic [10:0]        thresh_reg;
  logic [8:0]         max_pass_reg;
  logic signed [15:0] means [64];
  logic signed [26:0] sums [64];
  logic [10:0]        counts [8];
  logic [3:0]         member [1024];
  logic signed [15:0] point_coords [8];
  logic [10:0]        changes;
  logic [8:0]         passes;

  out_item_t expected_results[$];

  assign pending = expected_results.size();

  function automatic int clamp8(input logic [3:0] v);
    if (v < 1) return 1;
    if (v > 8) return 8;
    return int'(v);
  endfunction

  task automatic clear_sums();
    for (int k = 0; k < 64; k++) sums[k] = '0;
    for (int c = 0; c < 8; c++) counts[c] = '0;
    changes = '0;
  endtask

  // Applies one accepted word to the shadow state and queues its result, if any.
  task automatic cluster_word(input in_item_t w);
    int nd, nc, best_c, k;
    longint diff, sq_sum, best, s, q;
    logic conv, lim;
    out_item_t r;
    nd = clamp8(dims_reg);
    nc = clamp8(clusters_reg);
    r = '0;
    case (w.opcode)
      OP_LOAD_MEAN: begin
        if (w.item_index < 8) means[w.item_index * 8 + w.coord_index] = w.coord_value;
      end
      OP_POINT: begin
        point_coords[w.coord_index] = w.coord_value;
        if (w.coord_index == nd - 1) begin
          best = 0;
          best_c = 0;
          for (int c = 0; c < nc; c++) begin
            sq_sum = 0;
            for (int d = 0; d < nd; d++) begin
              diff = longint'(point_coords[d]) - longint'(means[c * 8 + d]);
              sq_sum += diff * diff;
            end
            // Strict compare keeps the lower index on a tie.
            if (c == 0 || sq_sum < best) begin
              best = sq_sum;
              best_c = c;
            end
          end
          r.result_kind = 1'b0;
          r.point_number = w.item_index;
          r.nearest_cluster = best_c[2:0];
          r.membership_changed = (member[w.item_index] != best_c[3:0]);
          if (r.membership_changed) begin
            member[w.item_index] = best_c[3:0];
            if (changes != CHANGE_SAT) changes = changes + 1'b1;
          end
          counts[best_c] = counts[best_c] + 1'b1;
          for (int d = 0; d < nd; d++) begin
            k = best_c * 8 + d;
            sums[k] = sums[k] + {{11{point_coords[d][15]}}, point_coords[d]};
          end
          expected_results.push_back(r);
        end
      end
      OP_END_PASS: begin
        conv = (changes < thresh_reg);
        if (passes != PASS_SAT) passes = passes + 1'b1;
        lim = (passes >= max_pass_reg);
        // Non-empty clusters move to the truncated mean unless the pass converged.
        if (!conv) begin
          for (int c = 0; c < nc; c++) begin
            if (counts[c] != 0) begin
              for (int d = 0; d < nd; d++) begin
                k = c * 8 + d;
                s = sums[k];
                q = s / longint'(counts[c]);
                if (q > 32767) q = 32767;
                if (q < -32768) q = -32768;
                means[k] = q[15:0];
              end
            end
          end
        end
        r.result_kind = 1'b1;
        r.change_count = changes;
        r.converged = conv;
        r.pass_limit_hit = lim;
        r.passes_done = passes;
        expected_results.push_back(r);
        clear_sums();
        if (conv || lim) passes = '0;
      end
      default: ;
    endcase
  endtask

  // Results are compared before the word accepted at the same edge is applied.
  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      dims_reg = 4'd8;
      clusters_reg = 4'd8;
      thresh_reg = 11'd1;
      max_pass_reg = 9'd300;
      for (int k = 0; k < 64; k++) means[k] = '0;
      for (int d = 0; d < 8; d++) point_coords[d] = '0;
      for (int p = 0; p < 1024; p++) member[p] = NO_CLUSTER;
      clear_sums();
      passes = '0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word at %0t: %p", $realtime, out_item);
        end else begin
          e = expected_results.pop_front();
          if (out_item.result_kind !== e.result_kind ||
              out_item.point_number !== e.point_number ||
              out_item.nearest_cluster !== e.nearest_cluster ||
              out_item.membership_changed !== e.membership_changed ||
              out_item.change_count !== e.change_count ||
              out_item.converged !== e.converged ||
              out_item.pass_limit_hit !== e.pass_limit_hit ||
              out_item.passes_done !== e.passes_done) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch at %0t: expected %p actual %p",
                       $realtime, e, out_item);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_DIMS:     dims_reg = pwdata[3:0];
          REG_CLUSTERS: clusters_reg = pwdata[3:0];
          REG_THRESH:   thresh_reg = pwdata[10:0];
          REG_MAXPASS:  max_pass_reg = pwdata[8:0];
          default: ;
        endcase
      end
      if (start && !busy) cluster_word(in_item);
    end
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
module testbench
  import kmc_pkg::*;
;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;

  // Stimulus bookkeeping.
  int                 dims_now;
  bit                 allow_idle;
  int                 words_sent;
  logic signed [15:0] pool_coords [32][8];

  kmeans_cluster_pass u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  kmc_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .pready(pready), .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Watchdog for a hung block.
  initial begin
    #60_000_000;
    $display("kmeans_cluster_pass verification failed");
    $finish;
  end

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 4000)) - 16'sd2000;
    endcase
  endfunction

  // Sends one word, with an optional idle burst first, and returns once it is taken.
  task automatic send_word(input logic [1:0] op, input logic [9:0] idx,
                           input logic [2:0] dim, input logic signed [15:0] val);
    in_item_t w;
    w.opcode = op;
    w.item_index = idx;
    w.coord_index = dim;
    w.coord_value = val;
    if (allow_idle && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    start <= 1'b1;
    in_item <= w;
    #1;
    while (busy) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
    words_sent++;
  endtask

  task automatic send_point(input logic [9:0] idx, input int pool_slot);
    for (int d = 0; d < dims_now; d++)
      send_word(OP_POINT, idx, d[2:0], pool_coords[pool_slot][d]);
  endtask

  task automatic reg_write(input logic [1:0] reg_id, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_id, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Lets all outstanding results drain, plus time for result-free words in flight.
  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic set_config(input logic [3:0] dims, input logic [3:0] clusters,
                            input logic [10:0] thresh, input logic [8:0] maxp);
    drain();
    reg_write(REG_DIMS, {28'd0, dims});
    reg_write(REG_CLUSTERS, {28'd0, clusters});
    reg_write(REG_THRESH, {21'd0, thresh});
    reg_write(REG_MAXPASS, {23'd0, maxp});
    dims_now = (dims < 1) ? 1 : ((dims > 8) ? 8 : int'(dims));
  endtask

  // One phase of random Lloyd passes over a pool of persistent points.
  task automatic run_phase(input int budget);
    int pool_size, slot, stop_at;
    stop_at = words_sent + budget;
    while (words_sent < stop_at) begin
      pool_size = $urandom_range(4, 32);
      for (int p = 0; p < pool_size && words_sent < stop_at; p++) begin
        slot = $urandom_range(0, pool_size - 1);
        case ($urandom_range(0, 19))
          0: send_word(OP_LOAD_MEAN, 10'($urandom_range(0, 15)), 3'($urandom), rand_coord());
          1: send_word(2'd3, 10'($urandom), 3'($urandom), 16'($urandom));
          2: send_word(OP_POINT, 10'($urandom), 3'($urandom), rand_coord());
          3: begin
            for (int d = 0; d < 8; d++) pool_coords[slot][d] = rand_coord();
            send_point(10'(slot), slot);
          end
          4: send_point(10'($urandom), slot);
          default: send_point(10'(slot), slot);
        endcase
      end
      send_word(OP_END_PASS, 10'($urandom), 3'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    dims_now = 8;
    allow_idle = 1'b1;
    words_sent = 0;
    for (int s = 0; s < 32; s++)
      for (int d = 0; d < 8; d++) pool_coords[s][d] = rand_coord();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Every mean entry is written before any point completes.
    for (int c = 0; c < 8; c++)
      for (int d = 0; d < 8; d++)
        send_word(OP_LOAD_MEAN, 10'(c), 3'(d), rand_coord());

    // Directed: extreme coordinates, point indices at both ends, a tie,
    // ignored mean indices, the unused opcode and two pass ends.
    for (int d = 0; d < 8; d++) send_word(OP_POINT, 10'd0, 3'(d), 16'sh7fff);
    for (int d = 0; d < 8; d++) send_word(OP_POINT, 10'd1023, 3'(d), 16'sh8000);
    for (int d = 0; d < 8; d++) begin
      send_word(OP_LOAD_MEAN, 10'd4, 3'(d), 16'sd1000);
      send_word(OP_LOAD_MEAN, 10'd5, 3'(d), 16'sd1000);
    end
    for (int d = 0; d < 8; d++) send_word(OP_POINT, 10'd7, 3'(d), 16'sd1000);
    send_word(OP_LOAD_MEAN, 10'd900, 3'd7, 16'sh5555);
    send_word(2'd3, 10'h3ff, 3'd7, 16'shffff);
    send_word(OP_END_PASS, 10'd0, 3'd0, 16'sd0);
    send_word(OP_END_PASS, 10'd0, 3'd0, 16'sd0);

    // Random phases over settings including the extremes and clamped values.
    run_phase(150);
    set_config(4'd1, 4'd1, 11'd0, 9'd1);
    run_phase(80);
    set_config(4'd3, 4'd8, 11'd1024, 9'd300);
    run_phase(150);
    set_config(4'd0, 4'd0, 11'd2047, 9'd511);
    run_phase(60);
    set_config(4'd15, 4'd15, 11'd2, 9'd3);
    run_phase(170);
    set_config(4'd2, 4'd5, 11'd1, 9'd0);
    run_phase(150);
    set_config(4'd8, 4'd3, 11'd4, 9'd300);
    allow_idle = 1'b0;
    run_phase(150);
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (2500) @(negedge clk);
    if (fail_count == 0) begin
      $display("kmeans_cluster_pass verification clean");
    end else begin
      $display("kmeans_cluster_pass verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/kmc_pkg.sv
rtl/kmc_front.sv
rtl/kmc_back.sv
rtl/kmeans_cluster_pass.sv
test/kmc_checker.sv
test/testbench.sv
